[rtl/vmcr_pkg.sv]
// Shared types and constants of the video mode cell renderer.
package vmcr_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_VIDEO_MODE   = 2'd0;
    localparam logic [1:0] REG_INK_SELECT   = 2'd1;
    localparam logic [1:0] REG_FLASH_PERIOD = 2'd2;

    // Display mode codes
    localparam logic [2:0] MODE_SCREEN2 = 3'd1;
    localparam logic [2:0] MODE_EXTCOL  = 3'd2;
    localparam logic [2:0] MODE_COL64   = 3'd6;

    localparam logic [7:0] FLASH_PERIOD_RESET = 8'd30;

    // Request codes
    localparam logic REQ_RENDER    = 1'b0;
    localparam logic REQ_FRAME_END = 1'b1;

    typedef struct packed {
        logic [2:0] video_mode;
        logic [2:0] ink_select;
        logic [7:0] flash_period;
    } cfg_t;

    // Decode stage contents
    typedef struct packed {
        logic        is_frame;
        logic        single;
        logic [7:0]  row;
        logic [4:0]  col;
        logic [13:0] off1;
        logic [13:0] off2;
        logic [7:0]  bits1;
        logic [7:0]  bits2;
    } dec_t;

    // Colour stage contents
    typedef struct packed {
        logic        single;
        logic [7:0]  row;
        logic [4:0]  col;
        logic [13:0] off1;
        logic [13:0] off2;
        logic [15:0] bits;
        logic [3:0]  ink;
        logic [3:0]  paper;
    } col_t;

endpackage

[rtl/vmcr_if.sv]
// Valid/ready channel interfaces for cell requests and rendered cells.
interface vmcr_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] mem_line;
    logic [4:0] cell_column;
    logic [7:0] first_byte;
    logic [7:0] second_byte;

    modport source (output valid, req_type, mem_line, cell_column, first_byte, second_byte,
                    input ready);
    modport sink (input valid, req_type, mem_line, cell_column, first_byte, second_byte,
                  output ready);
endinterface

interface vmcr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] pixel_colours;
    logic [7:0]  screen_row;
    logic [4:0]  out_column;
    logic [13:0] first_offset;
    logic [13:0] second_offset;

    modport source (output valid, pixel_colours, screen_row, out_column, first_offset,
                    second_offset, input ready);
    modport sink (input valid, pixel_colours, screen_row, out_column, first_offset,
                  second_offset, output ready);
endinterface

[rtl/vmcr_decode.sv]
// First stage: screen row and fetch offset decode.
module vmcr_decode
    import vmcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vmcr_in_if.sink    cell_in,
    input  cfg_t       cfg,
    input  logic       take,
    output logic       valid,
    output dec_t       data
);

    logic valid_reg;
    logic valid_next;
    dec_t data_reg;
    dec_t data_next;
    logic enable;
    logic screen2;
    logic direct;

    // Advance when empty or when the next stage takes the held item
    assign enable        = !valid_reg || take;
    assign cell_in.ready = enable;

    // Decode row and offsets
    always_comb
    begin
        screen2 = (cfg.video_mode == MODE_SCREEN2);
        direct  = (cfg.video_mode == MODE_COL64) || (cfg.video_mode == MODE_EXTCOL);
        data_next.is_frame = (cell_in.req_type == REQ_FRAME_END);
        data_next.single   = (cfg.video_mode == MODE_COL64);
        data_next.row      = {cell_in.mem_line[7:6], cell_in.mem_line[2:0],
                              cell_in.mem_line[5:3]};
        data_next.col      = cell_in.cell_column;
        data_next.off1     = {screen2, cell_in.mem_line, cell_in.cell_column};
        if (direct)
        begin
            data_next.off2 = {1'b1, cell_in.mem_line, cell_in.cell_column};
        end
        else
        begin
            data_next.off2 = {screen2, 2'b11, 1'b0, cell_in.mem_line[7:6],
                              cell_in.mem_line[2:0], cell_in.cell_column};
        end
        data_next.bits1 = cell_in.first_byte;
        data_next.bits2 = cell_in.second_byte;
        valid_next      = enable ? cell_in.valid : valid_reg;
    end

    // Hold the valid bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on each transaction
    always_ff @(posedge clk)
    begin
        if (enable && cell_in.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

[rtl/vmcr_colour.sv]
// Second stage: flash counter and ink/paper selection.
module vmcr_colour
    import vmcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    input  dec_t in_data,
    output logic in_take,
    input  logic take,
    output logic valid,
    output col_t data
);

    logic       valid_reg;
    logic       valid_next;
    col_t       data_reg;
    col_t       data_next;
    logic [7:0] frame_count_reg;
    logic [7:0] frame_count_next;
    logic       flash_on_reg;
    logic       flash_on_next;
    logic [7:0] count_inc;
    logic       enable;
    logic       tick;
    logic [3:0] attr_ink;
    logic [3:0] attr_paper;
    logic       swap;

    assign enable  = !valid_reg || take;
    assign in_take = enable;
    assign tick    = enable && in_valid && in_data.is_frame;

    // Advance the flash counter on a frame end
    always_comb
    begin
        count_inc        = frame_count_reg + 8'd1;
        frame_count_next = frame_count_reg;
        flash_on_next    = flash_on_reg;
        if (tick)
        begin
            if (count_inc >= cfg.flash_period)
            begin
                frame_count_next = 8'd0;
                flash_on_next    = !flash_on_reg;
            end
            else
            begin
                frame_count_next = count_inc;
            end
        end
    end

    // Pick ink and paper; drop frame ends here
    always_comb
    begin
        attr_ink   = {in_data.bits2[6], in_data.bits2[2:0]};
        attr_paper = in_data.bits2[6:3];
        swap       = flash_on_reg && in_data.bits2[7];
        data_next.single = in_data.single;
        data_next.row    = in_data.row;
        data_next.col    = in_data.col;
        data_next.off1   = in_data.off1;
        data_next.off2   = in_data.off2;
        data_next.bits   = {in_data.bits1, in_data.bits2};
        if (in_data.single)
        begin
            data_next.ink   = {1'b0, cfg.ink_select};
            data_next.paper = {1'b0, ~cfg.ink_select};
        end
        else if (swap)
        begin
            data_next.ink   = attr_paper;
            data_next.paper = attr_ink;
        end
        else
        begin
            data_next.ink   = attr_ink;
            data_next.paper = attr_paper;
        end
        valid_next = enable ? (in_valid && !in_data.is_frame) : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            frame_count_reg <= 8'd0;
            flash_on_reg    <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            frame_count_reg <= frame_count_next;
            flash_on_reg    <= flash_on_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

[rtl/vmcr_pixel.sv]
// Third stage: expand the cell into sixteen colour indices and hold the result.
module vmcr_pixel
    import vmcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  col_t       in_data,
    output logic       in_take,
    vmcr_out_if.source cell_out
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] pix_reg;
    logic [63:0] pix_next;
    logic [7:0]  row_reg;
    logic [4:0]  col_reg;
    logic [13:0] off1_reg;
    logic [13:0] off2_reg;
    logic        enable;
    logic        bit_on;

    assign enable  = !valid_reg || cell_out.ready;
    assign in_take = enable;

    // Build pixels leftmost first; doubled modes repeat each bit of the first byte
    always_comb
    begin
        pix_next = '0;
        bit_on   = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            if (in_data.single)
            begin
                bit_on = in_data.bits[15 - i];
            end
            else
            begin
                bit_on = in_data.bits[15 - (i / 2)];
            end
            pix_next[63 - 4 * i -: 4] = bit_on ? in_data.ink : in_data.paper;
        end
        valid_next = enable ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && in_valid)
        begin
            pix_reg  <= pix_next;
            row_reg  <= in_data.row;
            col_reg  <= in_data.col;
            off1_reg <= in_data.off1;
            off2_reg <= in_data.off2;
        end
    end

    assign cell_out.valid         = valid_reg;
    assign cell_out.pixel_colours = pix_reg;
    assign cell_out.screen_row    = row_reg;
    assign cell_out.out_column    = col_reg;
    assign cell_out.first_offset  = off1_reg;
    assign cell_out.second_offset = off2_reg;

endmodule

[rtl/video_mode_cell_renderer.sv]
// Video mode cell renderer: takes one cell request per cycle while the
// output is not stalled, through a three stage pipeline (decode, colour with
// flash counter, pixel expansion into the output register). Each stage
// advances when empty or when its successor takes its item, so bubbles close
// up under output back-pressure; requests are taken while earlier ones are in
// flight. Frame-end requests advance the flash counter in the colour stage and
// produce no result. The user must write configuration through cfg_we/cfg_index/
// cfg_data only while no request is in flight; the block does not enforce it.
module video_mode_cell_renderer
    import vmcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vmcr_in_if.sink    cell_in,
    vmcr_out_if.source cell_out,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic dec_valid;
    dec_t dec_data;
    logic dec_take;
    logic col_valid;
    col_t col_data;
    logic col_take;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_VIDEO_MODE:   cfg_next.video_mode   = cfg_data[2:0];
                REG_INK_SELECT:   cfg_next.ink_select   = cfg_data[2:0];
                REG_FLASH_PERIOD: cfg_next.flash_period = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.video_mode   <= 3'd0;
            cfg_reg.ink_select   <= 3'd0;
            cfg_reg.flash_period <= FLASH_PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vmcr_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_in (cell_in),
        .cfg     (cfg_reg),
        .take    (dec_take),
        .valid   (dec_valid),
        .data    (dec_data)
    );

    vmcr_colour u_colour (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (dec_valid),
        .in_data  (dec_data),
        .in_take  (dec_take),
        .take     (col_take),
        .valid    (col_valid),
        .data     (col_data)
    );

    vmcr_pixel u_pixel (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (col_valid),
        .in_data  (col_data),
        .in_take  (col_take),
        .cell_out (cell_out)
    );

`ifndef ASSERT_OFF
    // Input back-pressure only when every stage is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !cell_in.ready |-> (dec_valid && col_valid && cell_out.valid && !cell_out.ready))
    else $error("input stalled with room in the pipeline");

    // A new result comes only from a rendered cell in the colour stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cell_out.valid) |-> $past(col_valid))
    else $error("result without a cell in the colour stage");

    // The colour stage never holds a cell it has not been handed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(col_valid) |-> $past(dec_valid && !dec_data.is_frame))
    else $error("colour stage filled without a render transaction");
`endif

endmodule

[tb/sv/vmcr_cell_checker.sv]
// Checker for the cell renderer: predicts each rendered cell and compares it with the output.
module vmcr_cell_checker
    import vmcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vmcr_in_if         cell_in,
    vmcr_out_if        cell_out,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    localparam logic [13:0] SECOND_SCREEN = 14'h2000;
    localparam logic [13:0] ATTR_AREA     = 14'h1800;

    typedef struct packed {
        logic [63:0] pixels;
        logic [7:0]  row;
        logic [4:0]  col;
        logic [13:0] off1;
        logic [13:0] off2;
    } cell_result_t;

    // Shadow copies of the registers and the flash state
    logic [2:0] mode;
    logic [2:0] ink;
    logic [7:0] period;
    logic [7:0] flash_frames;
    logic       flash_phase;

    cell_result_t cells_due[$];
    int           errors;

    // Work out the rendered cell for one request under the current settings
    function automatic cell_result_t render_cell(input logic [7:0] line, input logic [4:0] col,
                                                 input logic [7:0] b1, input logic [7:0] b2);
        cell_result_t res;
        logic [3:0]   fg;
        logic [3:0]   bg;
        logic [3:0]   swap;
        logic [3:0]   c;
        logic [13:0]  base;
        logic [15:0]  bits;
        int           i;
        res.row  = {line[7:6], line[2:0], line[5:3]};
        res.col  = col;
        res.off1 = {1'b0, line, col};
        res.pixels = '0;
        if (mode == MODE_COL64)
        begin
            // Two bitmaps, one nibble per pixel, fixed ink and its complement
            res.off2 = res.off1 + SECOND_SCREEN;
            bits = {b1, b2};
            for (i = 15; i >= 0; i--)
            begin
                c = bits[i] ? {1'b0, ink} : {1'b0, 3'd7 - ink};
                res.pixels = {res.pixels[59:0], c};
            end
        end
        else
        begin
            if (mode == MODE_EXTCOL)
            begin
                res.off2 = res.off1 + SECOND_SCREEN;
            end
            else
            begin
                base = (mode == MODE_SCREEN2) ? SECOND_SCREEN : 14'd0;
                res.off1 = res.off1 + base;
                res.off2 = ATTR_AREA + {4'd0, res.row[7:3], col} + base;
            end
            // Attribute colours, swapped while flashing, each pixel doubled
            fg = {b2[6], b2[2:0]};
            bg = b2[6:3];
            if (flash_phase && b2[7])
            begin
                swap = fg;
                fg = bg;
                bg = swap;
            end
            for (i = 7; i >= 0; i--)
            begin
                c = b1[i] ? fg : bg;
                res.pixels = {res.pixels[55:0], c, c};
            end
        end
        return res;
    endfunction

    // Compare one field and report it on a mismatch
    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t exp_cell;
        if (!rst_n)
        begin
            mode = 3'd0;
            ink = 3'd0;
            period = FLASH_PERIOD_RESET;
            flash_frames = 8'd0;
            flash_phase = 1'b0;
            cells_due.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VIDEO_MODE:   mode = cfg_data[2:0];
                    REG_INK_SELECT:   ink = cfg_data[2:0];
                    REG_FLASH_PERIOD: period = cfg_data;
                    default: ;
                endcase
            end

            // Check a rendered cell against the oldest one due
            if (cell_out.valid && cell_out.ready)
            begin
                if (cells_due.size() == 0)
                begin
                    $display("%0t: unexpected cell, got pixels %h row %0d col %0d", $time,
                             cell_out.pixel_colours, cell_out.screen_row, cell_out.out_column);
                    errors++;
                end
                else
                begin
                    exp_cell = cells_due.pop_front();
                    check_field("pixel_colours", exp_cell.pixels, cell_out.pixel_colours);
                    check_field("screen_row", exp_cell.row, cell_out.screen_row);
                    check_field("out_column", exp_cell.col, cell_out.out_column);
                    check_field("first_offset", exp_cell.off1, cell_out.first_offset);
                    check_field("second_offset", exp_cell.off2, cell_out.second_offset);
                end
            end

            // Predict from an accepted request, or advance the flash counter
            if (cell_in.valid && cell_in.ready)
            begin
                if (cell_in.req_type == REQ_FRAME_END)
                begin
                    flash_frames = flash_frames + 8'd1;
                    if (flash_frames >= period)
                    begin
                        flash_frames = 8'd0;
                        flash_phase = !flash_phase;
                    end
                end
                else
                begin
                    cells_due.push_back(render_cell(cell_in.mem_line, cell_in.cell_column,
                                                    cell_in.first_byte, cell_in.second_byte));
                end
            end

            fail_count <= errors;
            pending <= cells_due.size();
        end
    end

endmodule

[tb/sv/video_mode_cell_renderer_tb.sv]
// Testbench top for the cell renderer: clock, reset, stimulus, back-pressure and verdict.
module video_mode_cell_renderer_tb
    import vmcr_pkg::*;
();

    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 80;
    localparam int HOLD_AFTER    = 150;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending;
    int         sent_count;
    int         idle_cycles;
    bit         quiet;
    bit         long_hold_done;

    vmcr_in_if  cell_in_ch();
    vmcr_out_if cell_out_ch();

    video_mode_cell_renderer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_in  (cell_in_ch),
        .cell_out (cell_out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    vmcr_cell_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_in   (cell_in_ch),
        .cell_out  (cell_out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cell_in_ch.valid && cell_in_ch.ready) ||
            (cell_out_ch.valid && cell_out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("video_mode_cell_renderer_tb NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls, one long hold-off, none at the end
    initial
    begin
        cell_out_ch.ready <= 1'b0;
        long_hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && sent_count >= HOLD_AFTER)
            begin
                cell_out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                cell_out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                cell_out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Offer one request, with an occasional gap first, and hold it until taken
    task automatic send_item(input logic req, input logic [7:0] line, input logic [4:0] col,
                             input logic [7:0] b1, input logic [7:0] b2);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            cell_in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        cell_in_ch.valid       <= 1'b1;
        cell_in_ch.req_type    <= req;
        cell_in_ch.mem_line    <= line;
        cell_in_ch.cell_column <= col;
        cell_in_ch.first_byte  <= b1;
        cell_in_ch.second_byte <= b2;
        @(posedge clk);
        while (!cell_in_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    // Drop valid and wait until every cell due has come out and the pipe is empty
    task automatic settle();
        cell_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Reprogramme all registers while idle, then send a stream of random requests
    task automatic run_phase(input logic [2:0] mode, input logic [2:0] ink,
                             input logic [7:0] period, input int count);
        logic       req;
        logic [7:0] line;
        settle();
        write_reg(REG_VIDEO_MODE, {5'd0, mode});
        write_reg(REG_INK_SELECT, {5'd0, ink});
        write_reg(REG_FLASH_PERIOD, period);
        cfg_we <= 1'b0;
        repeat (count)
        begin
            req = ($urandom_range(0, 99) < 15) ? REQ_FRAME_END : REQ_RENDER;
            line = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(192, 255))
                                               : 8'($urandom_range(0, 191));
            send_item(req, line, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_VIDEO_MODE;
        cfg_data <= 8'd0;
        cell_in_ch.valid <= 1'b0;
        cell_in_ch.req_type <= REQ_RENDER;
        cell_in_ch.mem_line <= 8'd0;
        cell_in_ch.cell_column <= 5'd0;
        cell_in_ch.first_byte <= 8'd0;
        cell_in_ch.second_byte <= 8'd0;
        sent_count = 0;
        quiet = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, lines past the visible area, flash bit with flash off
        send_item(REQ_RENDER, 8'd0, 5'd0, 8'h00, 8'h00);
        send_item(REQ_RENDER, 8'd191, 5'd31, 8'hFF, 8'hFF);
        send_item(REQ_RENDER, 8'd255, 5'd31, 8'hAA, 8'h55);
        send_item(REQ_RENDER, 8'd192, 5'd0, 8'h55, 8'hAA);
        send_item(REQ_RENDER, 8'd63, 5'd16, 8'h0F, 8'hF0);
        send_item(REQ_RENDER, 8'd7, 5'd1, 8'h80, 8'h47);
        send_item(REQ_RENDER, 8'd56, 5'd30, 8'h01, 8'hB8);
        send_item(REQ_FRAME_END, 8'hFF, 5'd31, 8'hFF, 8'hFF);
        send_item(REQ_FRAME_END, 8'd0, 5'd0, 8'h00, 8'h00);
        send_item(REQ_RENDER, 8'd128, 5'd10, 8'hC3, 8'hC7);

        // Every mode, ink extremes, flash periods including zero and the maximum
        run_phase(3'd0, 3'd0, 8'd1, 40);
        run_phase(MODE_SCREEN2, 3'd7, 8'd2, 40);
        run_phase(MODE_EXTCOL, 3'd3, 8'd0, 50);
        run_phase(MODE_COL64, 3'd0, 8'd255, 40);
        run_phase(MODE_COL64, 3'd7, 8'd3, 40);
        run_phase(3'd3, 3'd5, 8'd1, 30);
        run_phase(3'd4, 3'd1, 8'd4, 30);
        run_phase(3'd5, 3'd2, 8'd30, 30);
        run_phase(3'd7, 3'd6, 8'd1, 30);
        run_phase(MODE_EXTCOL, 3'd4, 8'd5, 50);

        // Last part without any idling on either side
        quiet = 1'b1;
        run_phase(MODE_SCREEN2, 3'd0, 8'd1, 30);

        settle();
        if (fail_count == 0)
        begin
            $display("video_mode_cell_renderer_tb OK");
        end
        else
        begin
            $display("video_mode_cell_renderer_tb NOT OK");
        end
        $finish;
    end

endmodule
